FILE: hw/rtl/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    localparam logic [4:0] MODE_ADD   = 5'd0;
    localparam logic [4:0] MODE_SUB   = 5'd1;
    localparam logic [4:0] MODE_MUL   = 5'd2;
    localparam logic [4:0] MODE_DIV   = 5'd3;
    localparam logic [4:0] MODE_LT    = 5'd4;
    localparam logic [4:0] MODE_LE    = 5'd5;
    localparam logic [4:0] MODE_GT    = 5'd6;
    localparam logic [4:0] MODE_GE    = 5'd7;
    localparam logic [4:0] MODE_EQ    = 5'd8;
    localparam logic [4:0] MODE_NE    = 5'd9;
    localparam logic [4:0] MODE_MIN   = 5'd10;
    localparam logic [4:0] MODE_MAX   = 5'd11;
    localparam logic [4:0] MODE_INC   = 5'd12;
    localparam logic [4:0] MODE_DEC   = 5'd13;
    localparam logic [4:0] MODE_FINT  = 5'd14;
    localparam logic [4:0] MODE_TINT  = 5'd15;
    localparam logic [4:0] MODE_FFLT  = 5'd16;
    localparam logic [4:0] MODE_TFLT  = 5'd17;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        K_SIMPLE = 3'd0,
        K_MUL    = 3'd1,
        K_DIV    = 3'd2,
        K_FFIX   = 3'd3,
        K_TFLT   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [31:0] res;
        logic        cmp;
        logic [1:0]  status;
        logic        is_div;
    } t_aux;

endpackage

FILE: hw/rtl/fpa_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
module fpa_div_pipe
    import fpa_pkg::*;
#(
    parameter int NW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [31:0]   i_den,
    input  logic          i_neg,
    input  t_aux          i_aux,
    output logic          o_valid,
    output logic [31:0]   o_quot,
    output t_aux          o_aux
);

    logic [NW-1:0] r_vld;
    logic [31:0]   r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [31:0]   r_quo [NW];
    logic [31:0]   r_den [NW];
    logic          r_neg [NW];
    t_aux          r_aux [NW];

    logic [NW-1:0] n_vld;
    logic [31:0]   n_rem [NW];
    logic [NW-1:0] n_num [NW];
    logic [31:0]   n_quo [NW];
    logic [31:0]   n_den [NW];
    logic          n_neg [NW];
    t_aux          n_aux [NW];

    logic [31:0]   w_rem [NW];
    logic [NW-1:0] w_num [NW];
    logic [31:0]   w_quo [NW];
    logic [32:0]   w_trial [NW];
    logic          w_ge [NW];

    always_comb begin
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                n_vld[k] = i_valid;
                w_rem[k] = '0;
                w_num[k] = i_num;
                w_quo[k] = '0;
                n_den[k] = i_den;
                n_neg[k] = i_neg;
                n_aux[k] = i_aux;
            end else begin
                n_vld[k] = r_vld[k-1];
                w_rem[k] = r_rem[k-1];
                w_num[k] = r_num[k-1];
                w_quo[k] = r_quo[k-1];
                n_den[k] = r_den[k-1];
                n_neg[k] = r_neg[k-1];
                n_aux[k] = r_aux[k-1];
            end
            w_trial[k] = {w_rem[k], w_num[k][NW-1]};
            w_ge[k]    = w_trial[k] >= {1'b0, n_den[k]};
            n_rem[k]   = w_ge[k] ? 32'(w_trial[k] - {1'b0, n_den[k]}) : w_trial[k][31:0];
            n_num[k]   = {w_num[k][NW-2:0], 1'b0};
            n_quo[k]   = {w_quo[k][30:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= n_vld;
        end
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= n_den[k];
                r_neg[k] <= n_neg[k];
                r_aux[k] <= n_aux[k];
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quot  = r_neg[NW-1] ? 32'(32'd0 - r_quo[NW-1]) : r_quo[NW-1];
    assign o_aux   = r_aux[NW-1];

endmodule

FILE: hw/rtl/fixed_point_alu.sv
// Top level of the pipelined signed fixed-point ALU.
//
// Channel   Direction  Accept                          Contents
// s_axis    in         s_axis_tvalid && s_axis_tready  mode, operand_a, operand_b
// m_axis    out        m_axis_tvalid && m_axis_tready  result_value, compare_true, status
//
// Every transaction passes through stages 1 to 4, the divider pipeline and the output
// register in that order; the divider pipeline computes one quotient bit per stage.
// One transaction is accepted per cycle unless the pipeline holds; all modes share the same latency.
// Reset clears the valid bits of every stage and of the output register.
// When the output is full and not taken, the whole pipeline holds.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // mode[4:0], operand_a[36:5], operand_b[68:37]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // result_value[31:0], compare_true[32], status[34:33]
);

    localparam int NW = 32 + FRAC_BITS;

    logic        en;
    logic [4:0]  in_mode;
    logic [31:0] in_a;
    logic [31:0] in_b;

    assign in_mode = s_axis_tdata[4:0];
    assign in_a    = s_axis_tdata[36:5];
    assign in_b    = s_axis_tdata[68:37];

    logic               r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    assign en            = !r_m_valid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: decode, simple results, multiply, conversion setup.
    logic        s1_lt;
    logic        s1_eq;
    t_kind       n1_kind;
    t_aux        n1_aux;
    logic [31:0] s1_abs_a;
    logic [31:0] s1_abs_b;
    logic [7:0]  s1_fexp;
    logic [7:0]  s1_fexp_eff;
    logic [23:0] n1_fm;
    logic [9:0]  n1_fe;

    logic          r1_vld;
    t_kind         r1_kind;
    t_aux          r1_aux;
    logic [63:0]   r1_prod;
    logic          r1_fsign;
    logic [23:0]   r1_fm;
    logic [9:0]    r1_fe;
    logic          r1_tsign;
    logic [31:0]   r1_tmag;
    logic [NW-1:0] r1_num;
    logic [31:0]   r1_den;
    logic          r1_neg;

    always_comb begin
        s1_lt       = $signed(in_a) < $signed(in_b);
        s1_eq       = in_a == in_b;
        s1_abs_a    = in_a[31] ? 32'(32'd0 - in_a) : in_a;
        s1_abs_b    = in_b[31] ? 32'(32'd0 - in_b) : in_b;
        s1_fexp     = in_a[30:23];
        s1_fexp_eff = (s1_fexp == 8'd0) ? 8'd1 : s1_fexp;
        n1_fm       = (s1_fexp == 8'd0) ? {1'b0, in_a[22:0]} : {1'b1, in_a[22:0]};
        n1_fe       = {2'b00, s1_fexp_eff} - 10'd150 + 10'(FRAC_BITS);
        n1_kind     = K_SIMPLE;
        n1_aux      = '{res: 32'd0, cmp: 1'b0, status: ST_OK, is_div: 1'b0};
        case (in_mode)
            MODE_ADD:  n1_aux.res = in_a + in_b;
            MODE_SUB:  n1_aux.res = in_a - in_b;
            MODE_MUL:  n1_kind = K_MUL;
            MODE_DIV: begin
                if (in_b == 32'd0) begin
                    n1_aux.status = ST_DIV0;
                end else begin
                    n1_kind       = K_DIV;
                    n1_aux.is_div = 1'b1;
                end
            end
            MODE_LT:   n1_aux.cmp = s1_lt;
            MODE_LE:   n1_aux.cmp = s1_lt || s1_eq;
            MODE_GT:   n1_aux.cmp = !s1_lt && !s1_eq;
            MODE_GE:   n1_aux.cmp = !s1_lt;
            MODE_EQ:   n1_aux.cmp = s1_eq;
            MODE_NE:   n1_aux.cmp = !s1_eq;
            MODE_MIN:  n1_aux.res = s1_lt ? in_a : in_b;
            MODE_MAX:  n1_aux.res = (!s1_lt && !s1_eq) ? in_a : in_b;
            MODE_INC:  n1_aux.res = in_a + 32'd1;
            MODE_DEC:  n1_aux.res = in_a - 32'd1;
            MODE_FINT: n1_aux.res = in_a << FRAC_BITS;
            MODE_TINT: n1_aux.res = 32'($signed(in_a) >>> FRAC_BITS);
            MODE_FFLT: begin
                if (s1_fexp == 8'hFF) begin
                    n1_aux.status = ST_RANGE;
                    if (in_a[22:0] != 23'd0) begin
                        n1_aux.res = 32'd0;
                    end else begin
                        n1_aux.res = in_a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end
                end else if (n1_fm != 24'd0 && !n1_fe[9] && n1_fe[8:5] != 4'd0) begin
                    n1_aux.status = ST_RANGE;
                    n1_aux.res    = in_a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    n1_kind = K_FFIX;
                end
            end
            MODE_TFLT: n1_kind = K_TFLT;
            default:   n1_kind = K_SIMPLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= s_axis_tvalid;
        end
        if (en) begin
            r1_kind  <= n1_kind;
            r1_aux   <= n1_aux;
            r1_prod  <= 64'($signed(in_a) * $signed(in_b));
            r1_fsign <= in_a[31];
            r1_fm    <= n1_fm;
            r1_fe    <= n1_fe;
            r1_tsign <= in_a[31];
            r1_tmag  <= s1_abs_a;
            r1_num   <= NW'(s1_abs_a) << FRAC_BITS;
            r1_den   <= s1_abs_b;
            r1_neg   <= in_a[31] ^ in_b[31];
        end
    end

    // Stage 2: product scaling, float mantissa shift, leading-one search.
    t_aux        n2_aux;
    logic [9:0]  s2_sh;
    logic [63:0] s2_sum;
    logic [63:0] s2_fmag;
    logic [4:0]  n2_tp;

    logic          r2_vld;
    t_kind         r2_kind;
    t_aux          r2_aux;
    logic          r2_fsign;
    logic [55:0]   r2_fmag;
    logic          r2_tsign;
    logic [31:0]   r2_tmag;
    logic [4:0]    r2_tp;
    logic [NW-1:0] r2_num;
    logic [31:0]   r2_den;
    logic          r2_neg;

    always_comb begin
        n2_aux = r1_aux;
        if (r1_kind == K_MUL) begin
            n2_aux.res = r1_prod[FRAC_BITS +: 32];
        end
        s2_sh  = 10'd0 - r1_fe;
        s2_sum = {40'd0, r1_fm} + (64'd1 << (s2_sh[5:0] - 6'd1));
        if (!r1_fe[9]) begin
            s2_fmag = {40'd0, r1_fm} << r1_fe[4:0];
        end else if (s2_sh > 10'd40) begin
            s2_fmag = 64'd0;
        end else begin
            s2_fmag = s2_sum >> s2_sh[5:0];
        end
        n2_tp = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (r1_tmag[i]) begin
                n2_tp = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
        if (en) begin
            r2_kind  <= r1_kind;
            r2_aux   <= n2_aux;
            r2_fsign <= r1_fsign;
            r2_fmag  <= s2_fmag[55:0];
            r2_tsign <= r1_tsign;
            r2_tmag  <= r1_tmag;
            r2_tp    <= n2_tp;
            r2_num   <= r1_num;
            r2_den   <= r1_den;
            r2_neg   <= r1_neg;
        end
    end

    // Stage 3: float-to-fixed sign and saturation, fixed-to-float rounding.
    t_aux        n3_aux;
    logic [4:0]  s3_sh;
    logic [31:0] s3_rem;
    logic [31:0] s3_half;
    logic [31:0] s3_mant;
    logic        s3_up;
    logic [24:0] n3_mant;

    logic          r3_vld;
    t_kind         r3_kind;
    t_aux          r3_aux;
    logic          r3_tsign;
    logic          r3_tzero;
    logic [4:0]    r3_tp;
    logic [24:0]   r3_mant;
    logic [NW-1:0] r3_num;
    logic [31:0]   r3_den;
    logic          r3_neg;

    always_comb begin
        n3_aux = r2_aux;
        if (r2_kind == K_FFIX) begin
            if (r2_fsign) begin
                if (r2_fmag > 56'h0_8000_0000) begin
                    n3_aux.res    = 32'h8000_0000;
                    n3_aux.status = ST_RANGE;
                end else begin
                    n3_aux.res = 32'(32'd0 - r2_fmag[31:0]);
                end
            end else begin
                if (r2_fmag > 56'h0_7FFF_FFFF) begin
                    n3_aux.res    = 32'h7FFF_FFFF;
                    n3_aux.status = ST_RANGE;
                end else begin
                    n3_aux.res = r2_fmag[31:0];
                end
            end
        end
        s3_sh   = r2_tp - 5'd23;
        s3_rem  = r2_tmag & ((32'd1 << s3_sh) - 32'd1);
        s3_half = 32'd1 << (s3_sh - 5'd1);
        s3_mant = r2_tmag >> s3_sh;
        s3_up   = (s3_rem > s3_half) || ((s3_rem == s3_half) && s3_mant[0]);
        if (r2_tp <= 5'd23) begin
            n3_mant = 25'(r2_tmag << (5'd23 - r2_tp));
        end else begin
            n3_mant = {1'b0, s3_mant[23:0]} + {24'd0, s3_up};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
        if (en) begin
            r3_kind  <= r2_kind;
            r3_aux   <= n3_aux;
            r3_tsign <= r2_tsign;
            r3_tzero <= r2_tmag == 32'd0;
            r3_tp    <= r2_tp;
            r3_mant  <= n3_mant;
            r3_num   <= r2_num;
            r3_den   <= r2_den;
            r3_neg   <= r2_neg;
        end
    end

    // Stage 4: fixed-to-float renormalize and pack.
    t_aux        n4_aux;
    logic [5:0]  s4_p;
    logic [24:0] s4_mant;
    logic [9:0]  s4_bexp;

    logic          r4_vld;
    t_aux          r4_aux;
    logic [NW-1:0] r4_num;
    logic [31:0]   r4_den;
    logic          r4_neg;

    always_comb begin
        n4_aux  = r3_aux;
        s4_p    = {1'b0, r3_tp} + {5'd0, r3_mant[24]};
        s4_mant = r3_mant[24] ? (r3_mant >> 1) : r3_mant;
        s4_bexp = {4'd0, s4_p} + 10'd127 - 10'(FRAC_BITS);
        if (r3_kind == K_TFLT) begin
            n4_aux.res = r3_tzero ? 32'd0 : {r3_tsign, s4_bexp[7:0], s4_mant[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
        if (en) begin
            r4_aux <= n4_aux;
            r4_num <= r3_num;
            r4_den <= r3_den;
            r4_neg <= r3_neg;
        end
    end

    logic        div_valid;
    logic [31:0] div_quot;
    t_aux        div_aux;

    fpa_div_pipe #(
        .NW (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_vld),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_neg   (r4_neg),
        .i_aux   (r4_aux),
        .o_valid (div_valid),
        .o_quot  (div_quot),
        .o_aux   (div_aux)
    );

    logic [OUT_TDATA_W-1:0] n_m_data;

    always_comb begin
        if (div_aux.is_div) begin
            n_m_data = {5'd0, ST_OK, 1'b0, div_quot};
        end else begin
            n_m_data = {5'd0, div_aux.status, div_aux.cmp, div_aux.res};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= div_valid;
        end
        if (en) begin
            r_m_data <= n_m_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
